// ----- rtl/core/ppfs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants for the pixel persistence fade scaler.
// No dependencies; every file of the block but ppfs_ram refers to this package.
package ppfs_pkg;

  // Field widths
  localparam int COL_W      = 6;
  localparam int ROW_W      = 5;
  localparam int LEVEL_W    = 8;
  localparam int RGB_W      = 24;
  localparam int SCALE_W    = 4;
  localparam int PITCH_W    = 10;
  localparam int DECAY_W    = 8;
  localparam int BYTE_OFF_W = 19;
  localparam int BPP_SHIFT  = 2;                       // four bytes per target pixel
  localparam int OFF_W      = BYTE_OFF_W - BPP_SHIFT;  // offset in pixels, wraps
  localparam int TX_W       = 9;                       // column * scale, at most 63*8
  localparam int TY_W       = 8;                       // row * scale, at most 31*8
  localparam int IDX_W      = 17;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FADE_ENABLE      = 3'd0,
    CFG_DECAY_STEP       = 3'd1,
    CFG_FOREGROUND_RGB   = 3'd2,
    CFG_BACKGROUND_RGB   = 3'd3,
    CFG_PIXEL_SCALE      = 3'd4,
    CFG_TARGET_ROW_PITCH = 3'd5
  } cfg_idx_e;

  // Register reset values
  localparam logic               FADE_RST  = 1'b0;
  localparam logic [DECAY_W-1:0] DECAY_RST = 8'd16;
  localparam logic [RGB_W-1:0]   FG_RST    = 24'hFF_FFFF;
  localparam logic [RGB_W-1:0]   BG_RST    = 24'h00_0000;
  localparam logic [SCALE_W-1:0] SCALE_RST = 4'd1;
  localparam logic [PITCH_W-1:0] PITCH_RST = 10'd64;

  // Levels
  localparam logic [LEVEL_W-1:0] LIT_LEVEL  = 8'hFF;
  localparam logic [LEVEL_W-1:0] DARK_LEVEL = 8'h00;

  // Parameter defaults
  localparam int SRC_WIDTH_DEF  = 64;
  localparam int SRC_HEIGHT_DEF = 32;
  localparam int MAX_SCALE_DEF  = 8;

  // One resolved source pixel handed to the replication stage
  typedef struct packed {
    logic [OFF_W-1:0]   base;   // pixel offset of the top-left target pixel
    logic [RGB_W-1:0]   rgb;
    logic [LEVEL_W-1:0] level;
  } ppfs_item_t;

endpackage

// ----- rtl/core/ppfs_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the source pixel input and target pixel output.
// Depends on ppfs_pkg for field widths.
interface ppfs_in_if;
  logic                        valid;
  logic                        ready;
  logic [ppfs_pkg::COL_W-1:0]   column;
  logic [ppfs_pkg::ROW_W-1:0]   row;
  logic [ppfs_pkg::LEVEL_W-1:0] raw_value;

  modport source (output valid, column, row, raw_value, input ready);
  modport sink   (input valid, column, row, raw_value, output ready);
endinterface

interface ppfs_out_if;
  logic                           valid;
  logic                           ready;
  logic [ppfs_pkg::BYTE_OFF_W-1:0] byte_offset;
  logic [7:0]                     red;
  logic [7:0]                     green;
  logic [7:0]                     blue;
  logic [ppfs_pkg::LEVEL_W-1:0]    alpha;
  logic                           last;

  modport source (output valid, byte_offset, red, green, blue, alpha, last, input ready);
  modport sink   (input valid, byte_offset, red, green, blue, alpha, last, output ready);
endinterface

// ----- rtl/core/pixel_persistence_fade_scaler.sv -----
`timescale 1ns / 1ps
// Top level of the pixel persistence fade scaler: config registers, level store, pipeline.
// Depends on ppfs_pkg, ppfs_if, ppfs_ram and ppfs_expander.
//
// Usage:
//   pix_i carries one source pixel (column, row, raw_value) per beat; pix_o carries
//   target pixels (byte_offset, red, green, blue, alpha, last), scale x scale beats
//   per in-range source pixel, columns outer and rows inner, last on the final one.
//   Source pixels outside the buffer are taken and produce no beats.
//   An input beat passes the stage 1 and stage 2 registers, then the output register.
//   Throughput: one input beat per cycle at scale one while pix_o.ready stays high; in
//   general the output side sets the pace, one target beat per cycle while it is high.
//   The per-pixel level lives in a RAM read in the input cycle and written back from
//   stage 1 as the item leaves it; a back-to-back repeat of the same pixel is forwarded.
//   Reset: after rst_ni releases, a clearing pass zeroes the level RAM, one entry a
//   cycle, all SRC_WIDTH*SRC_HEIGHT entries (2048 by default); pix_i.ready stays low
//   until it ends. Configuration writes are taken throughout.
//   Stall: with pix_o.ready low the output beat holds and the stages behind it fill;
//   pix_i.ready drops once the pipeline is full. Nothing is lost or repeated.
//   The user must change configuration only while the block is idle; it is not enforced.
module pixel_persistence_fade_scaler #(
  parameter int SRC_WIDTH  = ppfs_pkg::SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = ppfs_pkg::SRC_HEIGHT_DEF,
  parameter int MAX_SCALE  = ppfs_pkg::MAX_SCALE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ppfs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ppfs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ppfs_in_if.sink                           pix_i,
  ppfs_out_if.source                        pix_o
);

  localparam int DEPTH  = SRC_WIDTH * SRC_HEIGHT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TXP_W  = ppfs_pkg::COL_W + ppfs_pkg::SCALE_W;
  localparam int TYP_W  = ppfs_pkg::ROW_W + ppfs_pkg::SCALE_W;
  localparam int TYPP_W = ppfs_pkg::TY_W + ppfs_pkg::PITCH_W;

  // ---------------------------------------------------------------- config
  logic                           fade_q;
  logic [ppfs_pkg::DECAY_W-1:0]   decay_q;
  logic [ppfs_pkg::RGB_W-1:0]     fg_q, bg_q;
  logic [ppfs_pkg::SCALE_W-1:0]   scale_q, eff_scale;
  logic [ppfs_pkg::PITCH_W-1:0]   pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_q  <= ppfs_pkg::FADE_RST;
      decay_q <= ppfs_pkg::DECAY_RST;
      fg_q    <= ppfs_pkg::FG_RST;
      bg_q    <= ppfs_pkg::BG_RST;
      scale_q <= ppfs_pkg::SCALE_RST;
      pitch_q <= ppfs_pkg::PITCH_RST;
    end else if (cfg_we_i) begin
      unique case (ppfs_pkg::cfg_idx_e'(cfg_idx_i))
        ppfs_pkg::CFG_FADE_ENABLE:      fade_q  <= cfg_data_i[0];
        ppfs_pkg::CFG_DECAY_STEP:       decay_q <= cfg_data_i[ppfs_pkg::DECAY_W-1:0];
        ppfs_pkg::CFG_FOREGROUND_RGB:   fg_q    <= cfg_data_i[ppfs_pkg::RGB_W-1:0];
        ppfs_pkg::CFG_BACKGROUND_RGB:   bg_q    <= cfg_data_i[ppfs_pkg::RGB_W-1:0];
        ppfs_pkg::CFG_PIXEL_SCALE:      scale_q <= cfg_data_i[ppfs_pkg::SCALE_W-1:0];
        ppfs_pkg::CFG_TARGET_ROW_PITCH: pitch_q <= cfg_data_i[ppfs_pkg::PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero reads as one, anything above the limit is clamped
  always_comb begin
    eff_scale = scale_q;
    if (scale_q == '0) begin
      eff_scale = ppfs_pkg::SCALE_W'(1);
    end else if (32'(scale_q) > MAX_SCALE) begin
      eff_scale = ppfs_pkg::SCALE_W'(MAX_SCALE);
    end
  end

  // ---------------------------------------------------------------- clearing pass
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // ---------------------------------------------------------------- handshake
  logic s1_vld_q, s1_vld_d, s2_vld_q, s2_vld_d;
  logic exp_rdy, s1_out_ok, in_rdy, in_fire;

  assign s1_out_ok   = !s2_vld_q || exp_rdy;
  assign in_rdy      = !clr_busy_q && (!s1_vld_q || s1_out_ok);
  assign in_fire     = pix_i.valid && in_rdy;
  assign pix_i.ready = in_rdy;

  // ---------------------------------------------------------------- input stage
  logic [ppfs_pkg::IDX_W-1:0]                  idx_full;
  logic [AW-1:0]                               in_addr;
  logic                                        in_range;
  logic [ppfs_pkg::COL_W+ppfs_pkg::SCALE_W-1:0] tx_prod;
  logic [ppfs_pkg::ROW_W+ppfs_pkg::SCALE_W-1:0] ty_prod;

  assign idx_full = ppfs_pkg::IDX_W'(pix_i.row) * ppfs_pkg::IDX_W'(SRC_WIDTH)
                  + ppfs_pkg::IDX_W'(pix_i.column);
  assign in_addr  = idx_full[AW-1:0];
  assign in_range = (32'(pix_i.column) < SRC_WIDTH) && (32'(pix_i.row) < SRC_HEIGHT);
  assign tx_prod  = TXP_W'(pix_i.column) * TXP_W'(eff_scale);
  assign ty_prod  = TYP_W'(pix_i.row) * TYP_W'(eff_scale);

  // ---------------------------------------------------------------- stage 1: level update
  logic                          s1_inr_q;
  logic [AW-1:0]                 s1_addr_q;
  logic [ppfs_pkg::LEVEL_W-1:0]  s1_raw_q, s1_byp_val_q;
  logic                          s1_byp_q;
  logic [ppfs_pkg::TX_W-1:0]     s1_tx0_q;
  logic [ppfs_pkg::TY_W-1:0]     s1_ty0_q;
  logic [ppfs_pkg::LEVEL_W-1:0]  ram_rdata, s1_stored, s1_level, s1_new_level;
  logic [ppfs_pkg::RGB_W-1:0]    s1_rgb;
  logic                          s1_wr_en;
  logic [ppfs_pkg::TY_W+ppfs_pkg::PITCH_W-1:0] s1_typ;

  // Stored level, with the write that left stage 1 at this item's read forwarded
  assign s1_stored = s1_byp_q ? s1_byp_val_q : ram_rdata;

  always_comb begin
    if (!fade_q) begin
      s1_level = s1_raw_q;
    end else if (s1_raw_q == ppfs_pkg::LIT_LEVEL) begin
      s1_level = ppfs_pkg::LIT_LEVEL;
    end else begin
      s1_level = s1_stored;
    end
    s1_new_level = s1_level;
    if (fade_q && (s1_raw_q != ppfs_pkg::LIT_LEVEL)) begin
      s1_new_level = (s1_level > decay_q) ? (s1_level - decay_q) : ppfs_pkg::DARK_LEVEL;
    end
  end

  assign s1_rgb   = (s1_level != ppfs_pkg::DARK_LEVEL) ? fg_q : bg_q;
  assign s1_wr_en = s1_vld_q && s1_inr_q && s1_out_ok;
  assign s1_typ   = TYPP_W'(s1_ty0_q) * TYPP_W'(pitch_q);

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (!s1_vld_q || s1_out_ok) begin
      s1_vld_d = in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_inr_q     <= in_range;
      s1_addr_q    <= in_addr;
      s1_raw_q     <= pix_i.raw_value;
      s1_tx0_q     <= tx_prod[ppfs_pkg::TX_W-1:0];
      s1_ty0_q     <= ty_prod[ppfs_pkg::TY_W-1:0];
      s1_byp_q     <= s1_wr_en && (s1_addr_q == in_addr);
      s1_byp_val_q <= s1_new_level;
    end
  end

  // ---------------------------------------------------------------- level store
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [ppfs_pkg::LEVEL_W-1:0] ram_wdata;

  assign ram_we    = clr_busy_q || s1_wr_en;
  assign ram_waddr = clr_busy_q ? clr_cnt_q : s1_addr_q;
  assign ram_wdata = clr_busy_q ? ppfs_pkg::DARK_LEVEL : s1_new_level;

  ppfs_ram #(
    .WIDTH (ppfs_pkg::LEVEL_W),
    .DEPTH (DEPTH)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- stage 2: base offset
  logic [ppfs_pkg::TX_W-1:0]    s2_tx0_q;
  logic [ppfs_pkg::OFF_W-1:0]   s2_typ_q;
  logic [ppfs_pkg::RGB_W-1:0]   s2_rgb_q;
  logic [ppfs_pkg::LEVEL_W-1:0] s2_level_q;
  ppfs_pkg::ppfs_item_t         s2_item;

  // Out-of-range pixels are dropped here
  always_comb begin
    s2_vld_d = s2_vld_q;
    if (s1_out_ok) begin
      s2_vld_d = s1_vld_q && s1_inr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_out_ok && s1_vld_q) begin
      s2_tx0_q   <= s1_tx0_q;
      s2_typ_q   <= s1_typ[ppfs_pkg::OFF_W-1:0];
      s2_rgb_q   <= s1_rgb;
      s2_level_q <= s1_level;
    end
  end

  assign s2_item.base  = ppfs_pkg::OFF_W'(s2_tx0_q) + s2_typ_q;
  assign s2_item.rgb   = s2_rgb_q;
  assign s2_item.level = s2_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
    end
  end

  // ---------------------------------------------------------------- stage 3: replication
  ppfs_expander #(
    .MAX_SCALE (MAX_SCALE)
  ) u_expander (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (s2_vld_q),
    .item_i     (s2_item),
    .item_rdy_o (exp_rdy),
    .scale_i    (eff_scale),
    .pitch_i    (pitch_q),
    .pix_o      (pix_o)
  );

  // ---------------------------------------------------------------- checks
  a_no_accept_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !pix_i.ready)
    else $error("input taken during clearing pass");

  a_no_wb_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s1_wr_en)
    else $error("level write-back during clearing pass");

  a_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s1_wr_en && (s1_addr_q == in_addr) |=> s1_byp_q && s1_vld_q)
    else $error("same-pixel write-back not forwarded");

endmodule

// ----- rtl/core/ppfs_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module ppfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ppfs_expander.sv -----
`timescale 1ns / 1ps
// Replication stage: turns one resolved source pixel into scale x scale target beats.
// Depends on ppfs_pkg and ppfs_out_if; its registers are the block's output register.
module ppfs_expander #(
  parameter int MAX_SCALE = ppfs_pkg::MAX_SCALE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           item_vld_i,
  input  ppfs_pkg::ppfs_item_t           item_i,
  output logic                           item_rdy_o,
  input  logic [ppfs_pkg::SCALE_W-1:0]   scale_i,
  input  logic [ppfs_pkg::PITCH_W-1:0]   pitch_i,
  ppfs_out_if.source                     pix_o
);

  localparam int CNT_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  logic                           vld_q, vld_d;
  logic [CNT_W-1:0]               sx_q, sy_q;
  logic [ppfs_pkg::OFF_W-1:0]     off_q, row_start_q;
  logic [ppfs_pkg::RGB_W-1:0]     rgb_q;
  logic [ppfs_pkg::LEVEL_W-1:0]   level_q;
  logic [ppfs_pkg::SCALE_W-1:0]   smax;
  logic                           col_end, last_beat, out_fire, item_fire;

  // Position within the scale x scale block; sy runs inner
  assign smax      = scale_i - ppfs_pkg::SCALE_W'(1);
  assign col_end   = (ppfs_pkg::SCALE_W'(sy_q) == smax);
  assign last_beat = col_end && (ppfs_pkg::SCALE_W'(sx_q) == smax);
  assign out_fire  = vld_q && pix_o.ready;

  // Take a new pixel when empty or when the last beat leaves
  assign item_rdy_o = !vld_q || (out_fire && last_beat);
  assign item_fire  = item_vld_i && item_rdy_o;

  always_comb begin
    vld_d = vld_q;
    if (item_fire) begin
      vld_d = 1'b1;
    end else if (out_fire && last_beat) begin
      vld_d = 1'b0;
    end
  end

  // Beat counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      sx_q  <= '0;
      sy_q  <= '0;
    end else begin
      vld_q <= vld_d;
      if (item_fire) begin
        sx_q <= '0;
        sy_q <= '0;
      end else if (out_fire && !last_beat) begin
        if (col_end) begin
          sx_q <= sx_q + CNT_W'(1);
          sy_q <= '0;
        end else begin
          sy_q <= sy_q + CNT_W'(1);
        end
      end
    end
  end

  // Offsets step by one pixel per column and by the pitch per row
  always_ff @(posedge clk_i) begin
    if (item_fire) begin
      off_q       <= item_i.base;
      row_start_q <= item_i.base;
      rgb_q       <= item_i.rgb;
      level_q     <= item_i.level;
    end else if (out_fire && !last_beat) begin
      if (col_end) begin
        row_start_q <= row_start_q + ppfs_pkg::OFF_W'(1);
        off_q       <= row_start_q + ppfs_pkg::OFF_W'(1);
      end else begin
        off_q <= off_q + ppfs_pkg::OFF_W'(pitch_i);
      end
    end
  end

  assign pix_o.valid       = vld_q;
  assign pix_o.byte_offset = ppfs_pkg::BYTE_OFF_W'(off_q) << ppfs_pkg::BPP_SHIFT;
  assign pix_o.red         = rgb_q[23:16];
  assign pix_o.green       = rgb_q[15:8];
  assign pix_o.blue        = rgb_q[7:0];
  assign pix_o.alpha       = level_q;
  assign pix_o.last        = last_beat;

  // Counters stay inside the block while a pixel is held
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (ppfs_pkg::SCALE_W'(sx_q) <= smax) && (ppfs_pkg::SCALE_W'(sy_q) <= smax))
    else $error("replication counter beyond scale");

  // Final beat with nothing behind it empties the stage
  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && last_beat && !item_vld_i |=> !vld_q)
    else $error("stage still valid after final beat");

  // A stalled beat holds its offset and level
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !pix_o.ready |=> vld_q && $stable(off_q) && $stable(level_q))
    else $error("output beat changed while stalled");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for pixel_persistence_fade_scaler: directed table, then random phases.
// Depends on ppfs_pkg and the ppfs_in_if / ppfs_out_if channel interfaces of the RTL.
module tb;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 9;
  localparam int DRAIN_CYCLES    = 12;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int IDLE_PCT        = 37;
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 22;
  localparam int DIR_COUNT       = 21;
  localparam int STORE_DEPTH     = ppfs_pkg::SRC_WIDTH_DEF * ppfs_pkg::SRC_HEIGHT_DEF;

  localparam int COL_W      = ppfs_pkg::COL_W;
  localparam int ROW_W      = ppfs_pkg::ROW_W;
  localparam int LEVEL_W    = ppfs_pkg::LEVEL_W;
  localparam int RGB_W      = ppfs_pkg::RGB_W;
  localparam int SCALE_W    = ppfs_pkg::SCALE_W;
  localparam int PITCH_W    = ppfs_pkg::PITCH_W;
  localparam int DECAY_W    = ppfs_pkg::DECAY_W;
  localparam int BYTE_OFF_W = ppfs_pkg::BYTE_OFF_W;
  localparam int CFG_IDX_W  = ppfs_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = ppfs_pkg::CFG_DATA_W;

  // Register indexes the block does not decode; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam logic PIN  = 1'b1;
  localparam logic FREE = 1'b0;

  typedef struct packed {
    logic               fade;
    logic [DECAY_W-1:0] decay;
    logic [RGB_W-1:0]   fg;
    logic [RGB_W-1:0]   bg;
    logic [SCALE_W-1:0] scale;
    logic [PITCH_W-1:0] pitch;
  } settings_t;

  // One source pixel; pinned rows carry the level, color and first offset to expect
  typedef struct packed {
    logic [2:0]            cfg_set;
    logic [COL_W-1:0]      column;
    logic [ROW_W-1:0]      row;
    logic [LEVEL_W-1:0]    raw;
    logic                  pinned;
    logic [LEVEL_W-1:0]    pin_level;
    logic [RGB_W-1:0]      pin_rgb;
    logic [BYTE_OFF_W-1:0] pin_off;
  } src_px_t;

  typedef struct packed {
    logic [BYTE_OFF_W-1:0] byte_offset;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [LEVEL_W-1:0]    alpha;
    logic                  last;
  } target_px_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic steady;

  ppfs_in_if  pix_in ();
  ppfs_out_if pix_out ();

  pixel_persistence_fade_scaler u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_in),
    .pix_o      (pix_out)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow of the block: registers, per-pixel levels, pending target pixels
  settings_t          regs;
  logic [LEVEL_W-1:0] level_mem [0:STORE_DEPTH-1];
  target_px_t         pending_px [$];
  src_px_t            cur_px;
  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count = 0;

  settings_t dir_cfg [0:4] = '{
    '{ppfs_pkg::FADE_RST, ppfs_pkg::DECAY_RST, ppfs_pkg::FG_RST, ppfs_pkg::BG_RST,
      ppfs_pkg::SCALE_RST, ppfs_pkg::PITCH_RST},
    '{1'b1, 8'd16,  24'hFFFFFF, 24'h000000, 4'd0,  10'd0},
    '{1'b1, 8'd255, 24'h123456, 24'hABCDEF, 4'd15, 10'd512},
    '{1'b0, 8'd255, 24'hFFFFFF, 24'h000000, 4'd8,  10'd1023},
    '{1'b1, 8'd0,   24'h00FF00, 24'hFF0000, 4'd2,  10'd1}
  };

  // Directed rows: reset state, extremes, relight, decay to zero, clamps, wrap
  src_px_t dir_rows [0:DIR_COUNT-1] = '{
    '{3'd0, 6'd0,  5'd0,  8'd0,   PIN,  8'h00, 24'h000000, 19'd0},
    '{3'd0, 6'd63, 5'd31, 8'd255, PIN,  8'hFF, 24'hFFFFFF, 19'd8188},
    '{3'd0, 6'd1,  5'd0,  8'd1,   PIN,  8'h01, 24'hFFFFFF, 19'd4},
    '{3'd0, 6'd42, 5'd21, 8'd170, FREE, 8'h00, 24'h000000, 19'd0},
    '{3'd0, 6'd21, 5'd10, 8'd85,  FREE, 8'h00, 24'h000000, 19'd0},
    '{3'd1, 6'd63, 5'd31, 8'd0,   PIN,  8'hFF, 24'hFFFFFF, 19'd252},
    '{3'd1, 6'd63, 5'd31, 8'd7,   PIN,  8'hEF, 24'hFFFFFF, 19'd252},
    '{3'd1, 6'd0,  5'd0,  8'd255, PIN,  8'hFF, 24'hFFFFFF, 19'd0},
    '{3'd1, 6'd1,  5'd0,  8'd0,   PIN,  8'h01, 24'hFFFFFF, 19'd4},
    '{3'd1, 6'd1,  5'd0,  8'd0,   PIN,  8'h00, 24'h000000, 19'd4},
    '{3'd2, 6'd63, 5'd31, 8'd255, PIN,  8'hFF, 24'h123456, 19'd509920},
    '{3'd2, 6'd0,  5'd0,  8'd0,   PIN,  8'hFF, 24'h123456, 19'd0},
    '{3'd2, 6'd0,  5'd0,  8'd0,   PIN,  8'h00, 24'hABCDEF, 19'd0},
    '{3'd2, 6'd63, 5'd31, 8'd254, FREE, 8'h00, 24'h000000, 19'd0},
    '{3'd3, 6'd63, 5'd31, 8'd200, PIN,  8'hC8, 24'hFFFFFF, 19'd492544},
    '{3'd3, 6'd32, 5'd16, 8'd85,  FREE, 8'h00, 24'h000000, 19'd0},
    '{3'd3, 6'd0,  5'd0,  8'd0,   PIN,  8'h00, 24'h000000, 19'd0},
    '{3'd3, 6'd10, 5'd10, 8'd128, FREE, 8'h00, 24'h000000, 19'd0},
    '{3'd4, 6'd10, 5'd10, 8'd3,   PIN,  8'h80, 24'h00FF00, 19'd160},
    '{3'd4, 6'd10, 5'd10, 8'd3,   PIN,  8'h80, 24'h00FF00, 19'd160},
    '{3'd4, 6'd10, 5'd10, 8'd255, PIN,  8'hFF, 24'h00FF00, 19'd160}
  };

  // Level update and scale x scale replication for one accepted source pixel
  function automatic void replicate_pixel(input src_px_t p);
    logic [10:0]           slot;
    logic [LEVEL_W-1:0]    lvl;
    logic [LEVEL_W-1:0]    shown;
    logic [RGB_W-1:0]      rgb;
    logic [BYTE_OFF_W-1:0] off0;
    int unsigned           sc;
    int unsigned           tx0;
    int unsigned           ty0;
    target_px_t            t;
    slot = {p.row, p.column};
    lvl  = level_mem[slot];
    if (!regs.fade) lvl = p.raw;
    else if (p.raw == ppfs_pkg::LIT_LEVEL) lvl = ppfs_pkg::LIT_LEVEL;
    rgb   = (lvl != ppfs_pkg::DARK_LEVEL) ? regs.fg : regs.bg;
    shown = lvl;
    sc = (regs.scale == 0) ? 1 :
         (regs.scale > ppfs_pkg::MAX_SCALE_DEF) ? ppfs_pkg::MAX_SCALE_DEF : regs.scale;
    tx0  = p.column * sc;
    ty0  = p.row * sc;
    off0 = BYTE_OFF_W'((tx0 + ty0 * regs.pitch) << ppfs_pkg::BPP_SHIFT);
    if (p.pinned) begin
      shown = p.pin_level;
      rgb   = p.pin_rgb;
      off0  = p.pin_off;
    end
    // columns outer, rows inner
    for (int unsigned sx = 0; sx < sc; sx++) begin
      for (int unsigned sy = 0; sy < sc; sy++) begin
        t.byte_offset = off0 + BYTE_OFF_W'((sx + sy * regs.pitch) << ppfs_pkg::BPP_SHIFT);
        t.red   = rgb[23:16];
        t.green = rgb[15:8];
        t.blue  = rgb[7:0];
        t.alpha = shown;
        t.last  = (sx + 1 == sc) && (sy + 1 == sc);
        pending_px.push_back(t);
      end
    end
    // unlit pixels fade after the render, floor at dark
    if (regs.fade && p.raw != ppfs_pkg::LIT_LEVEL)
      lvl = (lvl > regs.decay) ? lvl - regs.decay : ppfs_pkg::DARK_LEVEL;
    level_mem[slot] = lvl;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic settings_t random_settings();
    settings_t s;
    int pick;
    s.fade = ($urandom_range(0, 99) < 70);
    pick = $urandom_range(0, 9);
    s.decay = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : DECAY_W'($urandom_range(1, 80));
    s.fg = RGB_W'($urandom);
    s.bg = RGB_W'($urandom);
    pick = $urandom_range(0, 19);
    if (pick == 0)      s.scale = 4'd0;
    else if (pick == 1) s.scale = 4'd8;
    else if (pick == 2) s.scale = SCALE_W'($urandom_range(9, 15));
    else if (pick < 8)  s.scale = SCALE_W'($urandom_range(2, 3));
    else                s.scale = 4'd1;
    pick = $urandom_range(0, 9);
    if (pick == 0)      s.pitch = 10'd0;
    else if (pick == 1) s.pitch = 10'd1023;
    else if (pick == 2) s.pitch = 10'd512;
    else                s.pitch = PITCH_W'($urandom_range(1, 1023));
    return s;
  endfunction

  // Mostly fade/relight runs around one hot spot, some noise anywhere
  function automatic src_px_t random_pixel(input logic [COL_W-1:0] hot_col,
                                           input logic [ROW_W-1:0] hot_row);
    src_px_t p;
    int pick;
    p = '0;
    if ($urandom_range(0, 99) < 80) begin
      p.column = hot_col + COL_W'($urandom_range(0, 2));
      p.row    = hot_row + ROW_W'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      p.raw = (pick < 25) ? ppfs_pkg::LIT_LEVEL :
              (pick < 85) ? ppfs_pkg::DARK_LEVEL : LEVEL_W'($urandom);
    end else begin
      p.column = COL_W'($urandom);
      p.row    = ROW_W'($urandom);
      p.raw    = LEVEL_W'($urandom);
    end
    return p;
  endfunction

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
  endtask

  // Writes all registers back to back, junk above non-color fields, plus one undecoded index
  task automatic load_settings(input settings_t s);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    cfg_we <= 1'b1;
    put_reg(ppfs_pkg::CFG_FADE_ENABLE,      {junk[23:1], s.fade});
    put_reg(ppfs_pkg::CFG_DECAY_STEP,       {junk[23:8], s.decay});
    put_reg(ppfs_pkg::CFG_FOREGROUND_RGB,   s.fg);
    put_reg(ppfs_pkg::CFG_BACKGROUND_RGB,   s.bg);
    put_reg(ppfs_pkg::CFG_PIXEL_SCALE,      {junk[23:4], s.scale});
    put_reg(ppfs_pkg::CFG_TARGET_ROW_PITCH, {junk[23:10], s.pitch});
    put_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, junk);
    cfg_we <= 1'b0;
    regs = s;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic drive_pixel(input src_px_t p);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      pix_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    cur_px = p;
    pix_in.valid     <= 1'b1;
    pix_in.column    <= p.column;
    pix_in.row       <= p.row;
    pix_in.raw_value <= p.raw;
    @(posedge clk_i);
    while (pix_in.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid, drain every expected target pixel, then let the pipe empty
  task automatic drain_beats();
    pix_in.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sink backpressure
  always @(negedge clk_i)
    pix_out.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

  // Source pixel taken
  always @(posedge clk_i)
    if (pix_in.valid === 1'b1 && pix_in.ready === 1'b1) replicate_pixel(cur_px);

  // Target pixel beat against the oldest expectation
  always @(posedge clk_i) begin
    target_px_t exp_px;
    if (pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
      if (pending_px.size() == 0) begin
        $error("unexpected target beat at byte_offset %0d", pix_out.byte_offset);
        mismatch_count++;
      end else begin
        exp_px = pending_px.pop_front();
        check_field("byte_offset", exp_px.byte_offset, pix_out.byte_offset);
        check_field("red",         exp_px.red,         pix_out.red);
        check_field("green",       exp_px.green,       pix_out.green);
        check_field("blue",        exp_px.blue,        pix_out.blue);
        check_field("alpha",       exp_px.alpha,       pix_out.alpha);
        check_field("last",        exp_px.last,        pix_out.last);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [2:0]       cur_set;
    logic [COL_W-1:0] hot_col;
    logic [ROW_W-1:0] hot_row;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = ppfs_pkg::CFG_FADE_ENABLE;
    cfg_data         = '0;
    pix_in.valid     = 1'b0;
    pix_in.column    = '0;
    pix_in.row       = '0;
    pix_in.raw_value = '0;
    pix_out.ready    = 1'b0;
    steady           = 1'b1;
    cur_px           = '0;
    regs             = dir_cfg[0];
    for (int i = 0; i < STORE_DEPTH; i++) level_mem[i] = ppfs_pkg::DARK_LEVEL;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table, back to back so repeats of one pixel hit the forward path
    cur_set = 3'd0;
    for (int i = 0; i < DIR_COUNT; i++) begin
      if (dir_rows[i].cfg_set != cur_set) begin
        drain_beats();
        cur_set = dir_rows[i].cfg_set;
        load_settings(dir_cfg[cur_set]);
      end
      drive_pixel(dir_rows[i]);
    end

    // Random phases, one of them without idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_beats();
      load_settings(random_settings());
      steady  = (ph == 1);
      hot_col = COL_W'($urandom);
      hot_row = ROW_W'($urandom);
      repeat (ITEMS_PER_PHASE) drive_pixel(random_pixel(hot_col, hot_row));
    end
    drain_beats();

    if (mismatch_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
